// ===== rtl/core/site_diversity_theta_accumulator_defines.svh =====
// Assertion macros for the site diversity and theta accumulator.
// Included by the modules that check their own logic; needs clk and rst in scope.
`ifndef SITE_DIVERSITY_THETA_ACCUMULATOR_DEFINES_SVH
`define SITE_DIVERSITY_THETA_ACCUMULATOR_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define SDTA_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define SDTA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/sdta_pkg.sv =====
// Shared constants, types and the reciprocal table for the theta accumulator.
// No dependencies; imported by every module of the block.
package sdta_pkg;

  localparam int MAX_IND   = 64;
  localparam int FRAC_W    = 24;
  localparam int H_FRAC    = 40;
  localparam int IDX_W     = 6;
  localparam int GT_W      = 2;
  localparam int ACC_W     = 56;
  localparam int MASK_W    = 64;
  localparam int IN_W      = 8;
  localparam int OUT_W     = 2 * ACC_W;
  localparam int CNT_W     = $clog2(MAX_IND + 1);
  localparam int ALT_W     = CNT_W + 1;
  localparam int DEN_W     = 2 * CNT_W + 1;
  localparam int REM_W     = 2 * ALT_W;
  localparam int QUO_W     = FRAC_W + 2;
  localparam int DIV_STEPS = FRAC_W + 2;
  localparam int DSTEP_W   = $clog2(DIV_STEPS);
  localparam int ROM_W     = FRAC_W + 1;

  localparam logic [GT_W-1:0]  GT_MISSING = 2'd3;
  localparam logic [ACC_W-1:0] ACC_MAX    = {ACC_W{1'b1}};

  // One closed site: sample count and alternate allele count
  typedef struct packed {
    logic [ALT_W-1:0] s;
    logic [CNT_W-1:0] n;
  } site_rec_t;

  // Queue fill status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef logic [ROM_W-1:0] recip_rom_t [0:MAX_IND];

  // Restoring long division, evaluated at elaboration only
  function automatic logic [127:0] bit_div(input logic [127:0] a, input logic [63:0] d);
    logic [64:0]  r;
    logic [127:0] q;
    r = '0;
    q = '0;
    for (int b = 127; b >= 0; b--) begin
      r = {r[63:0], a[b]};
      q = q << 1;
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // Entry n holds 1/H(2n-1), rounded to nearest with ties up
  function automatic recip_rom_t build_recip_rom();
    recip_rom_t   rom;
    logic [63:0]  h;
    logic [127:0] t;
    int           i;
    h = '0;
    i = 1;
    rom[0] = '0;
    for (int n = 1; n <= MAX_IND; n++) begin
      while (i <= 2 * n - 1) begin
        t = bit_div(128'd1 << (H_FRAC + 1), 64'(i));
        h = h + 64'((t + 128'd1) >> 1);
        i++;
      end
      t = bit_div(128'd1 << (H_FRAC + FRAC_W + 1), h);
      rom[n] = ROM_W'((t + 128'd1) >> 1);
    end
    return rom;
  endfunction

  localparam recip_rom_t RECIP_ROM = build_recip_rom();

endpackage

// ===== rtl/core/site_diversity_theta_accumulator.sv =====
// Flow: a monomorphic or empty site goes from the queue via the idle and accumulate states
// to the output register; a polymorphic site also passes the multiply state and the divider.
// Throughput: one genotype per cycle while the queue is not full; the back end takes one site
// at a time; a two-site queue lies between counting and the bit-serial pi division.
// Reset: synchronous active-high rst clears mask, counts, sums, queue and output; no sweep.
module site_diversity_theta_accumulator
  import sdta_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [MASK_W-1:0] cfg_wdata,   // population_mask
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_W-1:0]   s_tdata,     // [5:0] individual_index, [7:6] genotype
  input  logic              s_tlast,     // site_last
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata      // [55:0] pi_total, [111:56] theta_total
);

  q_status_t q_status;
  logic      push;
  site_rec_t push_rec;
  logic      pop;
  site_rec_t rd_rec;

  sdta_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .q_status  (q_status),
    .push      (push),
    .push_rec  (push_rec)
  );

  sdta_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .rd_rec   (rd_rec),
    .status   (q_status)
  );

  sdta_back u_back (
    .clk      (clk),
    .rst      (rst),
    .rd_rec   (rd_rec),
    .q_status (q_status),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ===== rtl/core/sdta_front.sv =====
// Front end: holds the population mask, counts sampled individuals per site.
// Depends on sdta_pkg; pushes one record per closed site into sdta_queue.
module sdta_front
  import sdta_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [MASK_W-1:0] cfg_wdata,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_W-1:0]   s_tdata,   // [5:0] individual_index, [7:6] genotype
  input  logic              s_tlast,   // site_last
  input  q_status_t         q_status,
  output logic              push,
  output site_rec_t         push_rec
);

  logic [MASK_W-1:0] population_mask;
  logic [CNT_W-1:0]  n_cnt;
  logic [ALT_W-1:0]  s_cnt;
  logic [IDX_W-1:0]  idx;
  logic [GT_W-1:0]   gt;
  logic              counted;
  logic              accept;
  logic [CNT_W-1:0]  n_next;
  logic [ALT_W-1:0]  s_next;

  assign idx      = s_tdata[IDX_W-1:0];
  assign gt       = s_tdata[IDX_W+GT_W-1:IDX_W];
  assign s_tready = !q_status.full;
  assign accept   = s_tvalid && s_tready;

  // Classify: in population, index in range, not missing, count not full
  assign counted = population_mask[idx]
                && ((IDX_W+1)'(idx) < (IDX_W+1)'(MAX_IND))
                && (gt != GT_MISSING)
                && (n_cnt < CNT_W'(MAX_IND));
  assign n_next  = n_cnt + CNT_W'(counted);
  assign s_next  = s_cnt + (counted ? ALT_W'(gt) : '0);

  // Hand the closed site to the back end
  assign push       = accept && s_tlast;
  assign push_rec.n = n_next;
  assign push_rec.s = s_next;

  // Write the mask register
  always_ff @(posedge clk) begin
    if (rst) begin
      population_mask <= '0;
    end else if (cfg_we) begin
      population_mask <= cfg_wdata;
    end
  end

  // Advance the counts; clear them when a site closes
  always_ff @(posedge clk) begin
    if (rst) begin
      n_cnt <= '0;
      s_cnt <= '0;
    end else if (accept) begin
      if (s_tlast) begin
        n_cnt <= '0;
        s_cnt <= '0;
      end else begin
        n_cnt <= n_next;
        s_cnt <= s_next;
      end
    end
  end

endmodule

// ===== rtl/core/sdta_queue.sv =====
// Two-entry queue of closed-site records between front and back end.
// Depends on sdta_pkg.
module sdta_queue
  import sdta_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  site_rec_t push_rec,
  input  logic      pop,
  output site_rec_t rd_rec,
  output q_status_t status
);

  site_rec_t  entry [0:1];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign status.full  = (count == 2'd2);
  assign status.empty = (count == 2'd0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign rd_rec       = entry[rd_ptr];

  // Store a pushed record
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_rec;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

// ===== rtl/core/sdta_back.sv =====
// Back end: per-site pi term by iterative division, theta term from the ROM,
// saturating sums and the output register. Depends on sdta_pkg and the defines.
`include "site_diversity_theta_accumulator_defines.svh"

module sdta_back
  import sdta_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  site_rec_t        rd_rec,
  input  q_status_t        q_status,
  output logic             pop,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata    // [55:0] pi_total, [111:56] theta_total
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_ACC  = 4'b1000
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   site_n;
  logic [ALT_W-1:0]   site_s;
  logic               poly;
  logic [DEN_W-1:0]   den;
  logic [REM_W-1:0]   rem;
  logic [QUO_W-1:0]   quo;
  logic [DSTEP_W-1:0] step;
  logic [ACC_W-1:0]   pi_acc;
  logic [ACC_W-1:0]   theta_acc;
  logic [ACC_W-1:0]   out_pi;
  logic [ACC_W-1:0]   out_theta;
  logic               out_valid;

  logic               rec_poly;
  logic [ALT_W-1:0]   two_n;
  logic [ALT_W-1:0]   two_n_minus_s;
  logic [ALT_W-1:0]   two_n_minus_1;
  logic               rem_ge;
  logic [REM_W-1:0]   rem_sub;
  logic [QUO_W-1:0]   quo_inc;
  logic [ROM_W-1:0]   pi_term;
  logic [ROM_W-1:0]   theta_term;
  logic [ACC_W:0]     pi_sum;
  logic [ACC_W:0]     theta_sum;
  logic [ACC_W-1:0]   pi_next;
  logic [ACC_W-1:0]   theta_next;
  logic               load;

  // Classify the queued site: polymorphic when 0 < s < 2n
  assign rec_poly = (rd_rec.n != '0) && (rd_rec.s != '0) && (rd_rec.s < {rd_rec.n, 1'b0});
  assign pop      = (state == S_IDLE) && !q_status.empty;

  assign two_n         = {site_n, 1'b0};
  assign two_n_minus_s = two_n - site_s;
  assign two_n_minus_1 = two_n - ALT_W'(1);

  // One quotient bit per step
  assign rem_ge  = rem >= REM_W'(den);
  assign rem_sub = rem_ge ? (rem - REM_W'(den)) : rem;

  // Round the pi term, look up the theta term, saturate both sums
  assign quo_inc    = quo + QUO_W'(1);
  assign pi_term    = quo_inc[QUO_W-1:1];
  assign theta_term = RECIP_ROM[site_n];
  assign pi_sum     = {1'b0, pi_acc} + (ACC_W+1)'(pi_term);
  assign theta_sum  = {1'b0, theta_acc} + (ACC_W+1)'(theta_term);
  assign pi_next    = !poly ? pi_acc : (pi_sum[ACC_W] ? ACC_MAX : pi_sum[ACC_W-1:0]);
  assign theta_next = !poly ? theta_acc
                    : (theta_sum[ACC_W] ? ACC_MAX : theta_sum[ACC_W-1:0]);

  assign load     = (state == S_ACC) && (!out_valid || m_tready);
  assign m_tvalid = out_valid;
  assign m_tdata  = {out_theta, out_pi};

  // Sequence one site: latch, multiply and divide (polymorphic sites only), accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (!q_status.empty) begin
            state <= rec_poly ? S_MUL : S_ACC;
          end
        end
        S_MUL: begin
          state <= S_DIV;
          step  <= '0;
        end
        S_DIV: begin
          step <= step + DSTEP_W'(1);
          if (step == DSTEP_W'(DIV_STEPS - 1)) begin
            state <= S_ACC;
          end
        end
        S_ACC: begin
          if (load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers of the divider
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        site_n <= rd_rec.n;
        site_s <= rd_rec.s;
        poly   <= rec_poly;
      end
      S_MUL: begin
        rem <= REM_W'(REM_W'(site_s) * REM_W'(two_n_minus_s));
        den <= DEN_W'(DEN_W'(site_n) * DEN_W'(two_n_minus_1));
        quo <= '0;
      end
      S_DIV: begin
        quo <= {quo[QUO_W-2:0], rem_ge};
        rem <= rem_sub << 1;
      end
      default: begin
      end
    endcase
  end

  // Hold the running sums
  always_ff @(posedge clk) begin
    if (rst) begin
      pi_acc    <= '0;
      theta_acc <= '0;
    end else if (load) begin
      pi_acc    <= pi_next;
      theta_acc <= theta_next;
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_pi    <= pi_next;
      out_theta <= theta_next;
    end
  end

  `SDTA_ASSERT(a_div_step_range, state == S_DIV, step < DSTEP_W'(DIV_STEPS), "divider step out of range")
  `SDTA_ASSERT(a_pi_term_le_one, (state == S_ACC) && poly, quo <= QUO_W'(2 ** (FRAC_W + 1)), "pi quotient above one")
  `SDTA_ASSERT_NEXT(a_pi_monotonic, load, pi_acc >= $past(pi_acc), "pi sum decreased")
  `SDTA_ASSERT_NEXT(a_theta_monotonic, load, theta_acc >= $past(theta_acc), "theta sum decreased")

endmodule

// ===== dv/site_diversity_theta_accumulator_tb.sv =====
// Self-checking testbench for site_diversity_theta_accumulator: genotype streams in,
// running pi and theta sums out, checked against an in-bench predictor of the sums.
// Depends on sdta_pkg and the block's RTL only.
module site_diversity_theta_accumulator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sdta_pkg::*;

  localparam int HOLD_CYCLES  = 500;
  localparam int DRAIN_SLACK  = 40;
  localparam int DRAIN_LIMIT  = 50000;
  localparam int PHASE_ITEMS  = 40;
  localparam int NUM_PHASES   = 8;
  localparam int HOLD_PHASE   = 4;
  localparam logic [ACC_W-1:0] ONE_FX = ACC_W'(1) << FRAC_W;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;
  typedef enum logic [0:0] {ROW_GENO, ROW_MASK} row_kind_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [GT_W-1:0]  gt;
    logic             last;
  } geno_req_t;

  typedef struct packed {
    logic [ACC_W-1:0] pi;
    logic [ACC_W-1:0] theta;
  } site_sums_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [MASK_W-1:0] mask;
    logic [IDX_W-1:0]  idx;
    logic [GT_W-1:0]   gt;
    logic              last;
    logic [7:0]        reps;
    logic              typed;
    logic [ACC_W-1:0]  pi;
    logic [ACC_W-1:0]  theta;
  } dir_row_t;

  localparam int DIR_ROWS = 22;
  localparam logic [MASK_W-1:0] ALL_ONES = {MASK_W{1'b1}};

  // Directed stimulus; typed sums only where obvious
  dir_row_t dir_table [0:DIR_ROWS-1] = '{
    '{ROW_GENO, '0, 6'd0,  2'd1, 1'b1, 8'd1,  1'b1, '0, '0},
    '{ROW_MASK, ALL_ONES, '0, '0, 1'b0, 8'd0, 1'b0, '0, '0},
    '{ROW_GENO, '0, 6'd0,  2'd1, 1'b1, 8'd1,  1'b1, ONE_FX, ONE_FX},
    '{ROW_GENO, '0, 6'd5,  2'd3, 1'b1, 8'd1,  1'b1, ONE_FX, ONE_FX},
    '{ROW_GENO, '0, 6'd63, 2'd0, 1'b0, 8'd1,  1'b0, '0, '0},
    '{ROW_GENO, '0, 6'd62, 2'd2, 1'b1, 8'd1,  1'b0, '0, '0},
    '{ROW_GENO, '0, 6'd10, 2'd2, 1'b0, 8'd1,  1'b0, '0, '0},
    '{ROW_GENO, '0, 6'd11, 2'd2, 1'b1, 8'd1,  1'b0, '0, '0},
    '{ROW_GENO, '0, 6'd20, 2'd0, 1'b1, 8'd1,  1'b0, '0, '0},
    '{ROW_GENO, '0, 6'd7,  2'd1, 1'b0, 8'd66, 1'b0, '0, '0},
    '{ROW_GENO, '0, 6'd8,  2'd2, 1'b1, 8'd1,  1'b0, '0, '0},
    '{ROW_MASK, {(MASK_W/2){2'b01}}, '0, '0, 1'b0, 8'd0, 1'b0, '0, '0},
    '{ROW_GENO, '0, 6'd1,  2'd1, 1'b0, 8'd1,  1'b0, '0, '0},
    '{ROW_GENO, '0, 6'd2,  2'd1, 1'b1, 8'd1,  1'b0, '0, '0},
    '{ROW_MASK, {1'b1, {(MASK_W-1){1'b0}}}, '0, '0, 1'b0, 8'd0, 1'b0, '0, '0},
    '{ROW_GENO, '0, 6'd63, 2'd1, 1'b0, 8'd1,  1'b0, '0, '0},
    '{ROW_GENO, '0, 6'd0,  2'd2, 1'b0, 8'd1,  1'b0, '0, '0},
    '{ROW_GENO, '0, 6'd63, 2'd3, 1'b1, 8'd1,  1'b0, '0, '0},
    '{ROW_MASK, ALL_ONES, '0, '0, 1'b0, 8'd0, 1'b0, '0, '0},
    '{ROW_GENO, '0, 6'd33, 2'd1, 1'b0, 8'd1,  1'b0, '0, '0},
    '{ROW_GENO, '0, 6'd34, 2'd2, 1'b0, 8'd1,  1'b0, '0, '0},
    '{ROW_GENO, '0, 6'd35, 2'd0, 1'b1, 8'd1,  1'b0, '0, '0}
  };

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [MASK_W-1:0] cfg_wdata = '0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata = '0;   // [5:0] individual_index, [7:6] genotype
  logic              s_tlast = 1'b0; // site_last
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_W-1:0]  m_tdata;        // [55:0] pi_total, [111:56] theta_total

  site_diversity_theta_accumulator u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // Predictor state: mask, open-site counts, running sums, reciprocal table
  logic [MASK_W-1:0] pop_mask = '0;
  logic [CNT_W-1:0]  site_n = '0;
  logic [ALT_W-1:0]  site_s = '0;
  logic [ACC_W-1:0]  pi_sum = '0;
  logic [ACC_W-1:0]  theta_sum = '0;
  logic [ACC_W-1:0]  theta_recip [0:MAX_IND];

  site_sums_t pending_sums [$];
  int         mismatch_count = 0;
  int         requests_sent = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  logic       hold_req = 1'b0;
  int         hold_left = 0;
  logic       hold_done = 1'b0;
  site_sums_t got_sums;
  site_sums_t want_sums;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [ACC_W-1:0] sat_sum(input logic [ACC_W-1:0] a,
                                               input logic [ACC_W-1:0] b);
    logic [63:0] t;
    t = 64'(a) + 64'(b);
    return (t > 64'(ACC_MAX)) ? ACC_MAX : t[ACC_W-1:0];
  endfunction

  // Count one request and close the site on last; returns 1 when sums go out
  function automatic logic predict_genotype(input geno_req_t g, output site_sums_t sums);
    logic [63:0] n64;
    logic [63:0] s64;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] quo;
    sums = '0;
    if (pop_mask[g.idx] && g.gt != GT_MISSING && site_n < CNT_W'(MAX_IND)) begin
      site_n = site_n + CNT_W'(1);
      site_s = site_s + ALT_W'(g.gt);
    end
    if (!g.last) return 1'b0;
    n64 = 64'(site_n);
    s64 = 64'(site_s);
    // Add terms only for a polymorphic site
    if (n64 != 0 && s64 != 0 && s64 < 2 * n64) begin
      num = s64 * (2 * n64 - s64);
      den = n64 * (2 * n64 - 1);
      quo = (num << (FRAC_W + 1)) / den;
      pi_sum    = sat_sum(pi_sum, ACC_W'((quo + 1) >> 1));
      theta_sum = sat_sum(theta_sum, theta_recip[site_n]);
    end
    site_n = '0;
    site_s = '0;
    sums.pi    = pi_sum;
    sums.theta = theta_sum;
    return 1'b1;
  endfunction

  task automatic set_idle(input idle_mode_t mode);
    send_idle_pct  = (mode == IDLE_SEND) ? 80 : (mode == IDLE_BOTH) ? 26 : 0;
    recv_stall_pct <= (mode == IDLE_RECV) ? 80 : (mode == IDLE_BOTH) ? 26 : 0;
  endtask

  // Offer one request, predict on acceptance
  task automatic send_request(input geno_req_t g, input logic typed,
                              input logic [ACC_W-1:0] pi, input logic [ACC_W-1:0] theta);
    site_sums_t sums;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {g.gt, g.idx};
    s_tlast  <= g.last;
    do @(posedge clk); while (!s_tready);
    requests_sent++;
    if (predict_genotype(g, sums)) begin
      if (typed) begin
        sums.pi    = pi;
        sums.theta = theta;
      end
      pending_sums.push_back(sums);
    end
  endtask

  // Stop offering and wait until all sums are back, then let the pipe settle
  task automatic drain_results();
    int guard;
    guard = 0;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_sums.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  task automatic write_mask(input logic [MASK_W-1:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    pop_mask = value;
  endtask

  // One random burst: noise, a long site with duplicates, or a short clean site
  task automatic send_random_site();
    int        shape;
    int        len;
    int        start;
    geno_req_t g;
    shape = $urandom_range(0, 99);
    if (shape < 10) begin
      len = $urandom_range(1, 8);
      for (int k = 0; k < len; k++) begin
        g.idx  = IDX_W'($urandom);
        g.gt   = GT_W'($urandom);
        g.last = ($urandom_range(0, 3) == 0);
        send_request(g, 1'b0, '0, '0);
      end
    end else if (shape < 16) begin
      len = $urandom_range(60, 80);
      for (int k = 0; k < len; k++) begin
        g.idx  = IDX_W'($urandom);
        g.gt   = ($urandom_range(0, 19) == 0) ? GT_MISSING : GT_W'($urandom_range(0, 2));
        g.last = (k == len - 1);
        send_request(g, 1'b0, '0, '0);
      end
    end else begin
      len   = $urandom_range(1, 16);
      start = $urandom_range(0, MAX_IND - 1);
      for (int k = 0; k < len; k++) begin
        g.idx  = IDX_W'(start + k);
        g.gt   = ($urandom_range(0, 9) == 0) ? GT_MISSING : GT_W'($urandom_range(0, 2));
        g.last = (k == len - 1);
        send_request(g, 1'b0, '0, '0);
      end
    end
  endtask

  // Receiver: check accepted sums, stall at random, hold off once on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready  <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got_sums.pi    = m_tdata[ACC_W-1:0];
        got_sums.theta = m_tdata[OUT_W-1:ACC_W];
        if (pending_sums.size() == 0) begin
          $error("unexpected result: pi_total %0h theta_total %0h",
                 got_sums.pi, got_sums.theta);
          mismatch_count++;
        end else begin
          want_sums = pending_sums.pop_front();
          if (got_sums.pi !== want_sums.pi) begin
            $error("pi_total: expected %0h actual %0h", want_sums.pi, got_sums.pi);
            mismatch_count++;
          end
          if (got_sums.theta !== want_sums.theta) begin
            $error("theta_total: expected %0h actual %0h", want_sums.theta, got_sums.theta);
            mismatch_count++;
          end
        end
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        m_tready  <= 1'b0;
      end else if (hold_req && !hold_done) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
        m_tready  <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        if (!hold_req) hold_done <= 1'b0;
      end
    end
  end

  initial begin
    logic [63:0]       h;
    logic [63:0]       q;
    logic [63:0]       r;
    int                i;
    geno_req_t         g;
    logic [MASK_W-1:0] mask;
    int                phase_start;

    // Build 1/H(2n-1): harmonic sum at 40 fraction bits, then long division
    h = '0;
    i = 1;
    theta_recip[0] = '0;
    for (int n = 1; n <= MAX_IND; n++) begin
      while (i <= 2 * n - 1) begin
        h = h + (((64'd1 << (H_FRAC + 1)) / 64'(i) + 64'd1) >> 1);
        i++;
      end
      q = (64'd1 << H_FRAC) / h;
      r = (64'd1 << H_FRAC) % h;
      for (int k = 0; k <= FRAC_W; k++) begin
        r = r << 1;
        q = q << 1;
        if (r >= h) begin
          r = r - h;
          q[0] = 1'b1;
        end
      end
      theta_recip[n] = ACC_W'((q + 64'd1) >> 1);
    end

    // Hold reset, then release it
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table
    set_idle(IDLE_NONE);
    for (int row = 0; row < DIR_ROWS; row++) begin
      if (dir_table[row].kind == ROW_MASK) begin
        write_mask(dir_table[row].mask);
      end else begin
        g.idx  = dir_table[row].idx;
        g.gt   = dir_table[row].gt;
        g.last = dir_table[row].last;
        for (int k = 0; k < dir_table[row].reps; k++)
          send_request(g, dir_table[row].typed, dir_table[row].pi, dir_table[row].theta);
      end
    end

    // Random phases over masks and idling patterns
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       mask = ALL_ONES;
        1:       mask = {$urandom, $urandom};
        2:       mask = {(MASK_W/2){2'b10}};
        3:       mask = {{(MASK_W/2){1'b0}}, {(MASK_W/2){1'b1}}};
        4:       mask = ALL_ONES;
        5:       mask = MASK_W'(1) << $urandom_range(0, MASK_W - 1);
        6:       mask = '0;
        default: mask = {$urandom, $urandom} | {$urandom, $urandom};
      endcase
      write_mask(mask);
      set_idle((p == HOLD_PHASE) ? IDLE_NONE : idle_mode_t'(p % 4));
      if (p == HOLD_PHASE) hold_req <= 1'b1;
      phase_start = requests_sent;
      while (requests_sent - phase_start < PHASE_ITEMS) send_random_site();
      if (p == HOLD_PHASE) hold_req <= 1'b0;
    end

    // Close the last open site so every count gets flushed
    g.idx  = '0;
    g.gt   = GT_MISSING;
    g.last = 1'b1;
    send_request(g, 1'b0, '0, '0);
    drain_results();
    if (pending_sums.size() != 0) begin
      $error("%0d expected results never arrived", pending_sums.size());
      mismatch_count++;
    end

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Run limit
  initial begin
    #4000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/sdta_pkg.sv
rtl/core/sdta_front.sv
rtl/core/sdta_queue.sv
rtl/core/sdta_back.sv
rtl/core/site_diversity_theta_accumulator.sv
dv/site_diversity_theta_accumulator_tb.sv
